FILE: design/ifs_pkg.sv
// ----------------------------------------------------------------------------
// ifs_pkg: shared types and constants for the chaos-game point generator
// Table layout, command codes and the beat payload types.
// ----------------------------------------------------------------------------
package ifs_pkg;

  localparam int MaxTransforms = 8;
  localparam int FracBits      = 16;
  localparam int CountBits     = 20;
  localparam int TableDepth    = 256;
  localparam int AddrBits      = 8;
  localparam int WordsPerT     = 32;
  localparam int NumCoeff      = 6;
  localparam int TBits         = 3;

  localparam logic [4:0] W_THRESH  = 5'd24;
  localparam logic [4:0] W_PERCENT = 5'd25;
  localparam logic [4:0] W_OFFSET  = 5'd28;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ITER  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  localparam logic [2:0] CFG_COUNT = 3'd0;
  localparam logic [2:0] CFG_FIRST = 3'd1;
  localparam logic [2:0] CFG_RED   = 3'd2;
  localparam logic [2:0] CFG_GREEN = 3'd3;
  localparam logic [2:0] CFG_BLUE  = 3'd4;

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         random_value;
    logic [7:0]         table_address;
    logic signed [31:0] table_word;
  } in_beat_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               counted;
    logic signed [31:0] box_x_min;
    logic signed [31:0] box_x_max;
    logic signed [31:0] box_y_min;
    logic signed [31:0] box_y_max;
  } out_beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return SMAX;
    if (v < -34'sh0_8000_0000) return SMIN;
    return v[31:0];
  endfunction

endpackage

FILE: design/ifs_stream_if.sv
// ----------------------------------------------------------------------------
// ifs_stream_if: valid/ready channel
// Carries one beat of a payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface ifs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ifs_table_ram.sv
// ----------------------------------------------------------------------------
// ifs_table_ram: transform table memory
// 256 x 32 single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ifs_table_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  addr,
  input  logic [31:0] wdata,
  output logic [31:0] rdata
);
  logic [31:0] mem [ifs_pkg::TableDepth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: design/ifs_chaos_game_point_generator_unit.sv
// ----------------------------------------------------------------------------
// ifs_chaos_game_point_generator_unit: IFS chaos-game point generator
// Picks a transform, applies its affine map and colour scaling, tracks the box.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | mode, random_value, table_address, table_word
//  out_ch  | out | result_kind, point, colour, counted, box
//  cfg     | in  | cfg_we, cfg_index, cfg_data (no handshake)
//
// Load: the word is written when the beat is taken, and ready stays high so
// loads go back to back. Iterate: threshold words are scanned (1 to 8), the
// twelve operand words fetched, the products formed, the colour channels
// scaled in turn, then point and box updated. Frame end: the six
// coefficients of each active transform (1 to 8) are stepped, all through the
// single table port. Reset (rst, sync) restores registers, not the table.
// One item at a time; a held result blocks the next item until taken.
// ----------------------------------------------------------------------------
module ifs_chaos_game_point_generator_unit (
  input  logic        clk,
  input  logic        rst,
  ifs_stream_if.sink   in_ch,
  ifs_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_OPND = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_COL  = 8'b0001_0000,
    S_ANIM = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_WAIT = 8'b1000_0000
  } state_t;

  state_t state;
  ifs_pkg::in_beat_t  cur;
  ifs_pkg::out_beat_t res;

  logic [3:0]  transform_count;
  logic [19:0] first_counted_step;
  logic [7:0]  start_red, start_green, start_blue;

  logic signed [31:0] cx, cy;
  logic [23:0]        colour;
  logic [19:0]        steps;
  logic signed [31:0] bx0, bx1, by0, by1;

  // ram port
  logic        we;
  logic [7:0]  addr;
  logic [31:0] wdata, rdata;
  ifs_table_ram u_ram (.clk, .we, .addr, .wdata, .rdata);

  logic [2:0] tsel, tlast;
  logic [3:0] widx;     // operand word / coefficient field counter
  logic       phase;    // 0: address issued, 1: data valid
  logic [2:0] coef;     // coefficient in frame end, channel in colour
  logic signed [31:0] w [12]; // a,b,e,c,d,f, pr,pg,pb, or,og,ob
  logic signed [31:0] anim_val, anim_lo, anim_hi, anim_st;
  logic signed [31:0] anim_new;
  logic [3:0] mstep;
  logic signed [63:0] prod;
  logic signed [33:0] acc;
  logic signed [31:0] nx;

  // colour channel datapath: ch * pct / 100 (toward zero) + off
  logic [7:0]         col_c;
  logic signed [31:0] col_pct, col_off;
  logic               pneg;
  logic [31:0]        pabs;   // |percent|
  logic [60:0]        recip;  // (|percent| >> 2) * ceil(2^35 / 25)
  logic [24:0]        pquo;   // |percent| / 100
  logic [6:0]         prem;   // |percent| mod 100
  logic [32:0]        qprod;  // ch * quotient
  logic [14:0]        rprod;  // ch * remainder
  logic [30:0]        rfrac;  // rprod * ceil(2^22 / 100)
  logic [32:0]        cmag;
  logic signed [34:0] csum;

  always_comb begin
    if (transform_count == 4'd0) tlast = 3'd0;
    else if (transform_count > 4'd8) tlast = 3'd7;
    else tlast = 3'(transform_count - 4'd1);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_WAIT);
  assign out_ch.data = res;

  assign anim_new = ifs_pkg::sat32(34'(anim_val) + 34'(anim_st));

  always_comb begin
    unique case (coef)
      3'd0: begin col_c = colour[23:16]; col_pct = w[6]; col_off = w[9]; end
      3'd1: begin col_c = colour[15:8];  col_pct = w[7]; col_off = w[10]; end
      default: begin col_c = colour[7:0]; col_pct = w[8]; col_off = w[11]; end
    endcase
  end

  assign rfrac = {16'd0, rprod} * {15'd0, 16'd41944};
  assign csum = (pneg ? -$signed({2'b00, cmag}) : $signed({2'b00, cmag})) + 35'(col_off);

  // operand word offsets for the iterate fetch
  function automatic logic [4:0] opnd_off(input logic [3:0] i);
    unique case (i)
      4'd0: return 5'd0;  4'd1: return 5'd4;  4'd2: return 5'd8;
      4'd3: return 5'd12; 4'd4: return 5'd16; 4'd5: return 5'd20;
      4'd6: return 5'd25; 4'd7: return 5'd26; 4'd8: return 5'd27;
      4'd9: return 5'd28; 4'd10: return 5'd29; default: return 5'd30;
    endcase
  endfunction

  function automatic logic signed [31:0] fxq(input logic signed [63:0] p);
    logic signed [47:0] q;
    q = p[63:16];
    if (q > 48'sh0000_7FFF_FFFF) return ifs_pkg::SMAX;
    if (q < -48'sh0000_8000_0000) return ifs_pkg::SMIN;
    return q[31:0];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [34:0] v);
    if (v > 35'sd255) return 8'd255;
    if (v < 35'sd0) return 8'd0;
    return v[7:0];
  endfunction

  always_comb begin
    we = 1'b0; wdata = '0;
    addr = {tsel, 5'd0};
    unique case (state)
      S_IDLE: begin
        addr = in_ch.data.table_address;
        we = in_ch.valid && in_ch.data.mode == ifs_pkg::MODE_LOAD;
        wdata = in_ch.data.table_word;
      end
      S_SCAN: addr = {tsel, ifs_pkg::W_THRESH};
      S_OPND: addr = {tsel, opnd_off(widx)};
      S_ANIM: begin
        addr = {tsel, coef, 2'(widx)};
        if (mstep == 4'd5) begin
          we = 1'b1; addr = {tsel, coef, 2'd0}; wdata = anim_new;
        end else if (mstep == 4'd6) begin
          we = 1'b1; addr = {tsel, coef, 2'd3};
          wdata = (anim_st == ifs_pkg::SMIN) ? ifs_pkg::SMAX : -anim_st;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      transform_count <= 4'd1; first_counted_step <= 20'd20;
      start_red <= 8'd255; start_green <= 8'd255; start_blue <= 8'd255;
      cx <= '0; cy <= '0; colour <= 24'hFFFFFF; steps <= '0;
      bx0 <= ifs_pkg::SMAX; bx1 <= ifs_pkg::SMIN;
      by0 <= ifs_pkg::SMAX; by1 <= ifs_pkg::SMIN;
      phase <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ifs_pkg::CFG_COUNT: transform_count <= cfg_data[3:0];
          ifs_pkg::CFG_FIRST: first_counted_step <= cfg_data;
          ifs_pkg::CFG_RED:   start_red <= cfg_data[7:0];
          ifs_pkg::CFG_GREEN: start_green <= cfg_data[7:0];
          ifs_pkg::CFG_BLUE:  start_blue <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          cur <= in_ch.data; tsel <= '0; phase <= 1'b0;
          widx <= '0; coef <= '0; mstep <= '0;
          if (in_ch.data.mode == ifs_pkg::MODE_ITER) state <= S_SCAN;
          else if (in_ch.data.mode == ifs_pkg::MODE_FRAME) begin
            res <= '{1'b1, 32'sd0, 32'sd0, 8'd0, 8'd0, 8'd0, 1'b0,
                     bx0, bx1, by0, by1};
            state <= S_ANIM;
          end
        end
        S_SCAN: begin
          phase <= ~phase;
          if (phase) begin
            if ($signed(rdata) > $signed({25'd0, cur.random_value}) ||
                tsel == tlast) begin
              state <= S_OPND; phase <= 1'b0;
            end else tsel <= tsel + 3'd1;
          end
        end
        S_OPND: begin
          phase <= ~phase;
          if (phase) begin
            w[widx] <= rdata;
            if (widx == 4'd11) begin
              state <= S_MUL; mstep <= '0;
            end else widx <= widx + 4'd1;
          end
        end
        S_MUL: begin
          // step 0..3 forms products; 1..4 accumulate registered product
          unique case (mstep)
            4'd0: begin prod <= w[0] * cx; mstep <= mstep + 4'd1; end
            4'd1: begin
              acc <= 34'(fxq(prod)) + 34'(w[2]); prod <= w[1] * cy;
              mstep <= mstep + 4'd1;
            end
            4'd2: begin
              nx <= ifs_pkg::sat32(acc + 34'(fxq(prod))); prod <= w[3] * cx;
              mstep <= mstep + 4'd1;
            end
            4'd3: begin
              acc <= 34'(fxq(prod)) + 34'(w[5]); prod <= w[4] * cy;
              mstep <= mstep + 4'd1;
            end
            default: begin
              res <= '{1'b0, nx, ifs_pkg::sat32(acc + 34'(fxq(prod))),
                       8'd0, 8'd0, 8'd0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
              state <= S_COL; mstep <= '0;
            end
          endcase
        end
        S_COL: begin
          // per channel: 0 sign, 1 reciprocal, 2 quotient, 3 remainder,
          // 4 remainder product, 5 magnitude, 6 sign, offset and clamp
          unique case (mstep)
            4'd0: begin
              pneg <= col_pct[31];
              pabs <= col_pct[31] ? (~col_pct + 32'd1) : col_pct;
            end
            4'd1: recip <= {31'd0, pabs[31:2]} * {30'd0, 31'd1374389535};
            4'd2: pquo <= recip[59:35];
            4'd3: begin
              prem <= 7'(pabs - 32'(pquo) * 32'd100);
              qprod <= {25'd0, col_c} * {8'd0, pquo};
            end
            4'd4: rprod <= {7'd0, col_c} * {8'd0, prem};
            4'd5: cmag <= qprod + {24'd0, rfrac[30:22]};
            default: begin
              unique case (coef)
                3'd0: res.red <= clamp8(csum);
                3'd1: res.green <= clamp8(csum);
                default: res.blue <= clamp8(csum);
              endcase
            end
          endcase
          if (mstep == 4'd6) begin
            mstep <= '0;
            if (coef == 3'd2) state <= S_OUT;
            else coef <= coef + 3'd1;
          end else mstep <= mstep + 4'd1;
        end
        S_OUT: begin
          cx <= res.point_x; cy <= res.point_y;
          colour <= {res.red, res.green, res.blue};
          if (steps != 20'hFFFFF) steps <= steps + 20'd1;
          if (((steps != 20'hFFFFF) ? steps + 20'd1 : steps) >= first_counted_step) begin
            res.counted <= 1'b1;
            if (res.point_x < bx0) bx0 <= res.point_x;
            if (res.point_x > bx1) bx1 <= res.point_x;
            if (res.point_y < by0) by0 <= res.point_y;
            if (res.point_y > by1) by1 <= res.point_y;
          end
          state <= S_WAIT;
        end
        S_ANIM: begin
          // 0..3 read val/lo/hi/st, 4 step word lands, 5 write val, 6 write step
          if (mstep < 4'd4) widx <= widx + 4'd1;
          if (mstep >= 4'd1 && mstep <= 4'd4) begin
            unique case (mstep)
              4'd1: anim_val <= rdata;
              4'd2: anim_lo <= rdata;
              4'd3: anim_hi <= rdata;
              default: anim_st <= rdata;
            endcase
          end
          if (mstep == 4'd6 || mstep == 4'd7) begin
            mstep <= '0; widx <= '0;
            if (coef == 3'd5) begin
              coef <= '0;
              if (tsel == tlast) begin
                cx <= '0; cy <= '0; steps <= '0;
                colour <= {start_red, start_green, start_blue};
                bx0 <= ifs_pkg::SMAX; bx1 <= ifs_pkg::SMIN;
                by0 <= ifs_pkg::SMAX; by1 <= ifs_pkg::SMIN;
                state <= S_WAIT;
              end else tsel <= tsel + 3'd1;
            end else coef <= coef + 3'd1;
          end else if (mstep == 4'd5 && !(anim_new > anim_hi || anim_new < anim_lo)) begin
            mstep <= 4'd7;  // inside limits: step word kept
          end else mstep <= mstep + 4'd1;
        end
        S_WAIT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
